[src/fjps_pkg.sv]
// ----------------------------------------------------------------------------
// fjps_pkg
// Shared types, constants and byte helpers for the flat JSON pair scanner.
// ----------------------------------------------------------------------------
package fjps_pkg;

  localparam int MAX_PAIRS  = 32;
  localparam int POS_W      = 14;
  localparam int CNT_W      = 6;
  localparam int IDX_W      = 5;

  localparam int LINK_DEPTH = 4;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int LINK_CW    = $clog2(LINK_DEPTH + 1);

  localparam int RES_DEPTH  = 4;
  localparam int RES_AW     = $clog2(RES_DEPTH);
  localparam int RES_CW     = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ESCAPE = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef enum logic [3:0] {
    PH_BRACE, PH_BETWEEN, PH_KEY, PH_AFTER_KEY, PH_AFTER_COLON,
    PH_STRING, PH_LITERAL, PH_NUMBER, PH_CLOSED, PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    CL_SPACE, CL_COMMA, CL_TAB, CL_NEWLINE, CL_OPEN, CL_CLOSE, CL_QUOTE,
    CL_COLON, CL_ESCAPE, CL_LIT_T, CL_LIT_F, CL_LIT_N, CL_OTHER
  } byte_class_t;

  typedef enum logic [1:0] {
    RK_PAIR  = 2'd0,
    RK_DONE  = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    VK_STRING = 3'd0,
    VK_TRUE   = 3'd1,
    VK_FALSE  = 3'd2,
    VK_NULL   = 3'd3,
    VK_NUMBER = 3'd4
  } value_kind_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             eom;
    logic [POS_W-1:0] pos;
    byte_class_t      cls;
  } link_item_t;

  typedef struct packed {
    result_kind_t     result_kind;
    logic [POS_W-1:0] key_offset;
    logic [POS_W-1:0] key_length;
    logic [POS_W-1:0] value_offset;
    logic [POS_W-1:0] value_length;
    value_kind_t      value_kind;
    logic [IDX_W-1:0] pair_index;
    logic [CNT_W-1:0] pair_count;
    logic             last_result;
  } result_t;

  typedef struct packed {
    logic    first_ok;
    logic    second_ok;
    result_t first;
    result_t second;
  } res_push_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b)
      CH_SPACE:  c = CL_SPACE;
      CH_COMMA:  c = CL_COMMA;
      CH_TAB:    c = CL_TAB;
      CH_NL:     c = CL_NEWLINE;
      CH_OPEN:   c = CL_OPEN;
      CH_CLOSE:  c = CL_CLOSE;
      CH_QUOTE:  c = CL_QUOTE;
      CH_COLON:  c = CL_COLON;
      CH_ESCAPE: c = CL_ESCAPE;
      8'h74:     c = CL_LIT_T;
      8'h66:     c = CL_LIT_F;
      8'h6E:     c = CL_LIT_N;
      default:   c = CL_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    logic [2:0] n;
    case (w)
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] ch;
    case ({w, p})
      {LIT_TRUE,  3'd0}: ch = 8'h74;
      {LIT_TRUE,  3'd1}: ch = 8'h72;
      {LIT_TRUE,  3'd2}: ch = 8'h75;
      {LIT_TRUE,  3'd3}: ch = 8'h65;
      {LIT_FALSE, 3'd0}: ch = 8'h66;
      {LIT_FALSE, 3'd1}: ch = 8'h61;
      {LIT_FALSE, 3'd2}: ch = 8'h6C;
      {LIT_FALSE, 3'd3}: ch = 8'h73;
      {LIT_FALSE, 3'd4}: ch = 8'h65;
      {LIT_NULL,  3'd0}: ch = 8'h6E;
      {LIT_NULL,  3'd1}: ch = 8'h75;
      {LIT_NULL,  3'd2}: ch = 8'h6C;
      {LIT_NULL,  3'd3}: ch = 8'h6C;
      default:           ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/fjps_front.sv]
// ----------------------------------------------------------------------------
// fjps_front
// Accepts message bytes, tags each with its offset and byte class.
// ----------------------------------------------------------------------------
module fjps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          data_byte,
  input  logic                end_of_message,
  input  logic                link_full,
  output logic                link_push,
  output fjps_pkg::link_item_t link_item
);
  import fjps_pkg::*;

  logic [POS_W-1:0] pos;

  assign link_push      = push && !link_full;
  assign link_item.data = data_byte;
  assign link_item.eom  = end_of_message;
  assign link_item.pos  = pos;
  assign link_item.cls  = classify(data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (link_push) begin
      pos <= end_of_message ? '0 : pos + POS_W'(1);
    end
  end

endmodule

[src/fjps_link_queue.sv]
// ----------------------------------------------------------------------------
// fjps_link_queue
// Short queue of classified bytes between the front and the scan stage.
// ----------------------------------------------------------------------------
module fjps_link_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  fjps_pkg::link_item_t wr_item,
  input  logic                 rd_en,
  output logic                 full,
  output logic                 not_empty,
  output fjps_pkg::link_item_t rd_item
);
  import fjps_pkg::*;

  link_item_t         mem [LINK_DEPTH];
  logic [LINK_AW-1:0] wr_ptr;
  logic [LINK_AW-1:0] rd_ptr;
  logic [LINK_CW-1:0] count;

  assign full      = (count == LINK_CW'(LINK_DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + LINK_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + LINK_AW'(1);
      end
      count <= count + LINK_CW'(wr_en) - LINK_CW'(rd_en);
    end
  end

endmodule

[src/fjps_scan.sv]
// ----------------------------------------------------------------------------
// fjps_scan
// Scan: walks the object grammar one byte per unstalled cycle, builds results.
// ----------------------------------------------------------------------------
module fjps_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  fjps_pkg::link_item_t item,
  input  logic                 res_room,
  output logic                 item_pop,
  output fjps_pkg::res_push_t  res_push
);
  import fjps_pkg::*;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] key_off, key_off_next;
  logic [POS_W-1:0] key_len, key_len_next;
  logic [POS_W-1:0] val_off, val_off_next;
  logic [2:0]       lit_prog, lit_prog_next;
  logic [1:0]       lit_which, lit_which_next;
  logic             esc, esc_next;
  logic [CNT_W-1:0] stored, stored_next;

  logic             take;
  logic             emit;
  value_kind_t      emit_kind;
  logic [POS_W-1:0] emit_len;
  logic             num_step;
  logic             bad;
  logic             pair_ok;
  logic [1:0]       w;
  logic [POS_W-1:0] end_pos;
  result_t          pair_res;
  result_t          done_res;

  assign take     = item_valid && res_room;
  assign item_pop = take;
  assign end_pos  = item.pos + POS_W'(1);
  assign w        = (lit_which == 2'd3) ? LIT_TRUE : lit_which;

  always_comb begin
    phase_next     = phase;
    key_off_next   = key_off;
    key_len_next   = key_len;
    val_off_next   = val_off;
    lit_prog_next  = lit_prog;
    lit_which_next = lit_which;
    esc_next       = esc;
    stored_next    = stored;
    emit           = 1'b0;
    emit_kind      = VK_NUMBER;
    emit_len       = '0;
    num_step       = 1'b0;
    bad            = 1'b0;
    pair_ok        = 1'b0;

    case (phase)
      PH_BRACE: begin
        phase_next = (item.cls == CL_OPEN) ? PH_BETWEEN : PH_ERROR;
      end
      PH_BETWEEN: begin
        case (item.cls)
          CL_SPACE, CL_COMMA, CL_TAB, CL_NEWLINE: ;
          CL_CLOSE: phase_next = PH_CLOSED;
          CL_QUOTE: begin
            key_off_next = end_pos;
            phase_next   = PH_KEY;
          end
          default: phase_next = PH_ERROR;
        endcase
      end
      PH_KEY: begin
        if (item.cls == CL_QUOTE) begin
          key_len_next = item.pos - key_off;
          phase_next   = PH_AFTER_KEY;
        end
      end
      PH_AFTER_KEY: begin
        if (item.cls == CL_COLON) begin
          phase_next = PH_AFTER_COLON;
        end else if (item.cls != CL_SPACE) begin
          phase_next = PH_ERROR;
        end
      end
      PH_AFTER_COLON: begin
        case (item.cls)
          CL_SPACE: ;
          CL_QUOTE: begin
            val_off_next = end_pos;
            esc_next     = 1'b0;
            phase_next   = PH_STRING;
          end
          CL_LIT_T, CL_LIT_F, CL_LIT_N: begin
            val_off_next   = item.pos;
            lit_which_next = (item.cls == CL_LIT_T) ? LIT_TRUE :
                             (item.cls == CL_LIT_F) ? LIT_FALSE : LIT_NULL;
            lit_prog_next  = 3'd1;
            phase_next     = PH_LITERAL;
          end
          default: begin
            val_off_next = item.pos;
            num_step     = 1'b1;
          end
        endcase
      end
      PH_STRING: begin
        if (esc) begin
          esc_next = 1'b0;
        end else if (item.cls == CL_ESCAPE) begin
          esc_next = 1'b1;
        end else if (item.cls == CL_QUOTE) begin
          emit       = 1'b1;
          emit_kind  = VK_STRING;
          emit_len   = item.pos - val_off;
          phase_next = PH_BETWEEN;
        end
      end
      PH_LITERAL: begin
        if (lit_prog < lit_len(w) && item.data == lit_char(w, lit_prog)) begin
          lit_prog_next = lit_prog + 3'd1;
          if (lit_prog_next >= lit_len(w)) begin
            emit = 1'b1;
            case (w)
              LIT_FALSE: emit_kind = VK_FALSE;
              LIT_NULL:  emit_kind = VK_NULL;
              default:   emit_kind = VK_TRUE;
            endcase
            emit_len   = '0;
            phase_next = PH_BETWEEN;
          end
        end else begin
          num_step = 1'b1;
        end
      end
      PH_NUMBER: begin
        num_step = 1'b1;
      end
      default: ;
    endcase

    if (num_step) begin
      case (item.cls)
        CL_COMMA, CL_SPACE: begin
          emit       = 1'b1;
          emit_kind  = VK_NUMBER;
          emit_len   = item.pos - val_off_next;
          phase_next = PH_BETWEEN;
        end
        CL_CLOSE: begin
          emit       = 1'b1;
          emit_kind  = VK_NUMBER;
          emit_len   = item.pos - val_off_next;
          phase_next = PH_CLOSED;
        end
        default: phase_next = PH_NUMBER;
      endcase
    end

    if (item.eom) begin
      case (phase_next)
        PH_AFTER_COLON: begin
          val_off_next = end_pos;
          emit         = 1'b1;
          emit_kind    = VK_NUMBER;
          emit_len     = '0;
        end
        PH_STRING: begin
          emit      = 1'b1;
          emit_kind = VK_STRING;
          emit_len  = end_pos - val_off_next;
        end
        PH_LITERAL, PH_NUMBER: begin
          emit      = 1'b1;
          emit_kind = VK_NUMBER;
          emit_len  = end_pos - val_off_next;
        end
        PH_BETWEEN, PH_CLOSED: ;
        default: bad = 1'b1;
      endcase
    end

    if (emit && stored < CNT_W'(MAX_PAIRS)) begin
      pair_ok     = 1'b1;
      stored_next = stored + CNT_W'(1);
    end

    pair_res.result_kind  = RK_PAIR;
    pair_res.key_offset   = key_off_next;
    pair_res.key_length   = key_len_next;
    pair_res.value_offset = val_off_next;
    pair_res.value_length = emit_len;
    pair_res.value_kind   = emit_kind;
    pair_res.pair_index   = stored[IDX_W-1:0];
    pair_res.pair_count   = stored + CNT_W'(1);
    pair_res.last_result  = !item.eom;

    done_res.result_kind  = bad ? RK_ERROR : RK_DONE;
    done_res.key_offset   = '0;
    done_res.key_length   = '0;
    done_res.value_offset = '0;
    done_res.value_length = '0;
    done_res.value_kind   = VK_STRING;
    done_res.pair_index   = '0;
    done_res.pair_count   = bad ? '0 : stored_next;
    done_res.last_result  = 1'b1;

    res_push.first_ok  = take && (pair_ok || item.eom);
    res_push.second_ok = take && pair_ok && item.eom;
    res_push.first     = pair_ok ? pair_res : done_res;
    res_push.second    = done_res;

    if (item.eom) begin
      phase_next     = PH_BRACE;
      key_off_next   = '0;
      key_len_next   = '0;
      val_off_next   = '0;
      lit_prog_next  = '0;
      lit_which_next = '0;
      esc_next       = 1'b0;
      stored_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BRACE;
      key_off   <= '0;
      key_len   <= '0;
      val_off   <= '0;
      lit_prog  <= '0;
      lit_which <= '0;
      esc       <= 1'b0;
      stored    <= '0;
    end else if (take) begin
      phase     <= phase_next;
      key_off   <= key_off_next;
      key_len   <= key_len_next;
      val_off   <= val_off_next;
      lit_prog  <= lit_prog_next;
      lit_which <= lit_which_next;
      esc       <= esc_next;
      stored    <= stored_next;
    end
  end

endmodule

[src/fjps_result_queue.sv]
// ----------------------------------------------------------------------------
// fjps_result_queue
// Output queue of results; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module fjps_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  fjps_pkg::res_push_t wr,
  input  logic                pop,
  output logic                room,
  output logic                empty,
  output fjps_pkg::result_t   head
);
  import fjps_pkg::*;

  result_t           mem [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr;
  logic [RES_AW-1:0] rd_ptr;
  logic [RES_CW-1:0] count;
  logic [RES_CW-1:0] push_n;
  logic              pop_ok;

  assign empty  = (count == '0);
  assign room   = (count <= RES_CW'(RES_DEPTH - 2));
  assign head   = mem[rd_ptr];
  assign pop_ok = pop && !empty;
  assign push_n = RES_CW'(wr.first_ok) + RES_CW'(wr.second_ok);

  always_ff @(posedge clk) begin
    if (wr.first_ok) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.second_ok) begin
      mem[wr_ptr + RES_AW'(1)] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[RES_AW-1:0];
      if (pop_ok) begin
        rd_ptr <= rd_ptr + RES_AW'(1);
      end
      count <= count + push_n - RES_CW'(pop_ok);
    end
  end

endmodule

[src/flat_json_pair_scanner_unit.sv]
// ----------------------------------------------------------------------------
// flat_json_pair_scanner_unit
// Scans a flat JSON object byte by byte and reports key/value pairs.
// ----------------------------------------------------------------------------
//   channel  | handshake         | payload
//   ---------+-------------------+-------------------------------------------
//   input    | push / full       | data_byte, end_of_message
//   result   | pop / empty       | result_kind .. last_result (one result)
//
// One byte per clock when no queue stalls: the front tags and queues bytes,
// the scan stage takes one byte a cycle from that queue; results are
// registered in the result queue. The scan stage waits while the result
// queue has fewer than two free entries, since one byte can yield a pair
// and a done. Synchronous reset clears both queues and the scan state.
// ----------------------------------------------------------------------------
module flat_json_pair_scanner_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] result_kind,
  output logic [fjps_pkg::POS_W-1:0] key_offset,
  output logic [fjps_pkg::POS_W-1:0] key_length,
  output logic [fjps_pkg::POS_W-1:0] value_offset,
  output logic [fjps_pkg::POS_W-1:0] value_length,
  output logic [2:0] value_kind,
  output logic [fjps_pkg::IDX_W-1:0] pair_index,
  output logic [fjps_pkg::CNT_W-1:0] pair_count,
  output logic       last_result
);
  import fjps_pkg::*;

  logic       link_push;
  link_item_t link_in;
  logic       link_full;
  logic       link_valid;
  link_item_t link_out;
  logic       link_pop;
  logic       res_room;
  res_push_t  res_push;
  result_t    head;

  fjps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .link_full      (link_full),
    .link_push      (link_push),
    .link_item      (link_in)
  );

  fjps_link_queue u_link (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (link_push),
    .wr_item   (link_in),
    .rd_en     (link_pop),
    .full      (link_full),
    .not_empty (link_valid),
    .rd_item   (link_out)
  );

  fjps_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (link_valid),
    .item       (link_out),
    .res_room   (res_room),
    .item_pop   (link_pop),
    .res_push   (res_push)
  );

  fjps_result_queue u_res (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .pop   (pop),
    .room  (res_room),
    .empty (empty),
    .head  (head)
  );

  assign full         = link_full;
  assign result_kind  = head.result_kind;
  assign key_offset   = head.key_offset;
  assign key_length   = head.key_length;
  assign value_offset = head.value_offset;
  assign value_length = head.value_length;
  assign value_kind   = head.value_kind;
  assign pair_index   = head.pair_index;
  assign pair_count   = head.pair_count;
  assign last_result  = head.last_result;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    link_pop |-> link_valid)
    else $error("scan stage popped an empty link queue");

  a_second_is_final: assert property (@(posedge clk) disable iff (rst)
    res_push.second_ok |-> (res_push.first_ok &&
      res_push.first.result_kind == RK_PAIR &&
      res_push.second.result_kind != RK_PAIR))
    else $error("bad result pairing in one cycle");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push.first_ok |-> res_room)
    else $error("result pushed without room");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Feeds flat JSON messages, one byte per word, into the pair scanner and
// checks every result word against a scanner model kept in the bench.
// Short directed messages come first, then random objects: mostly well
// formed with random content, some truncated, corrupted or pure noise, and
// one over the pair limit. The sender works in bursts, the receiver stalls
// on its own pattern and holds off once for a long stretch so that the
// input side backs up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fjps_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eom;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    push           = 1'b0;
  logic [7:0]              data_byte      = 8'h00;
  logic                    end_of_message = 1'b0;
  logic                    pop            = 1'b0;
  logic                    full;
  logic                    empty;
  logic [1:0]              result_kind;
  logic [POS_W-1:0]        key_offset;
  logic [POS_W-1:0]        key_length;
  logic [POS_W-1:0]        value_offset;
  logic [POS_W-1:0]        value_length;
  logic [2:0]              value_kind;
  logic [IDX_W-1:0]        pair_index;
  logic [CNT_W-1:0]        pair_count;
  logic                    last_result;

  flat_json_pair_scanner_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .pop           (pop),
    .empty         (empty),
    .result_kind   (result_kind),
    .key_offset    (key_offset),
    .key_length    (key_length),
    .value_offset  (value_offset),
    .value_length  (value_length),
    .value_kind    (value_kind),
    .pair_index    (pair_index),
    .pair_count    (pair_count),
    .last_result   (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- scanner model ----
  string      lit_words[3] = '{"true", "false", "null"};
  logic [7:0] gap_chars[4] = '{CH_SPACE, CH_TAB, CH_NL, CH_COMMA};
  string      num_chars    = "0123456789-+.eE";

  phase_t           sc_phase;
  logic [POS_W-1:0] sc_pos;
  logic [POS_W-1:0] sc_key_off;
  logic [POS_W-1:0] sc_key_len;
  logic [POS_W-1:0] sc_val_off;
  int unsigned      sc_lit_prog;
  logic [1:0]       sc_lit_sel;
  bit               sc_escaped;
  int unsigned      sc_kept;

  result_t byte_results[$];
  result_t scan_results_due[$];
  word_t   words_to_send[$];
  logic [7:0] msg[$];

  int error_count = 0;
  int bytes_in    = 0;

  function automatic void reset_scan();
    sc_phase    = PH_BRACE;
    sc_pos      = '0;
    sc_key_off  = '0;
    sc_key_len  = '0;
    sc_val_off  = '0;
    sc_lit_prog = 0;
    sc_lit_sel  = '0;
    sc_escaped  = 1'b0;
    sc_kept     = 0;
  endfunction

  task automatic push_pair(input value_kind_t kind, input logic [POS_W-1:0] vlen);
    result_t r;
    if (sc_kept >= MAX_PAIRS) return;
    r              = '0;
    r.result_kind  = RK_PAIR;
    r.key_offset   = sc_key_off;
    r.key_length   = sc_key_len;
    r.value_offset = sc_val_off;
    r.value_length = vlen;
    r.value_kind   = kind;
    r.pair_index   = sc_kept[IDX_W-1:0];
    sc_kept++;
    r.pair_count   = sc_kept[CNT_W-1:0];
    byte_results.push_back(r);
  endtask

  task automatic end_number(input logic [7:0] b);
    if (b == CH_COMMA || b == CH_SPACE) begin
      push_pair(VK_NUMBER, sc_pos - sc_val_off);
      sc_phase = PH_BETWEEN;
    end else if (b == CH_CLOSE) begin
      push_pair(VK_NUMBER, sc_pos - sc_val_off);
      sc_phase = PH_CLOSED;
    end else begin
      sc_phase = PH_NUMBER;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eom);
    logic [POS_W-1:0] end_pos;
    result_t          fin;
    string            word;
    bit               bad;
    byte_results = {};
    case (sc_phase)
      PH_BRACE: sc_phase = (b == CH_OPEN) ? PH_BETWEEN : PH_ERROR;
      PH_BETWEEN: begin
        if (b == CH_SPACE || b == CH_COMMA || b == CH_TAB || b == CH_NL) begin
        end else if (b == CH_CLOSE) begin
          sc_phase = PH_CLOSED;
        end else if (b == CH_QUOTE) begin
          sc_key_off = sc_pos + 1'b1;
          sc_phase   = PH_KEY;
        end else begin
          sc_phase = PH_ERROR;
        end
      end
      PH_KEY: begin
        if (b == CH_QUOTE) begin
          sc_key_len = sc_pos - sc_key_off;
          sc_phase   = PH_AFTER_KEY;
        end
      end
      PH_AFTER_KEY: begin
        if (b == CH_COLON) sc_phase = PH_AFTER_COLON;
        else if (b != CH_SPACE) sc_phase = PH_ERROR;
      end
      PH_AFTER_COLON: begin
        if (b == CH_SPACE) begin
        end else if (b == CH_QUOTE) begin
          sc_val_off = sc_pos + 1'b1;
          sc_escaped = 1'b0;
          sc_phase   = PH_STRING;
        end else if (b == "t" || b == "f" || b == "n") begin
          sc_val_off  = sc_pos;
          sc_lit_sel  = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
          sc_lit_prog = 1;
          sc_phase    = PH_LITERAL;
        end else begin
          sc_val_off = sc_pos;
          end_number(b);
        end
      end
      PH_STRING: begin
        if (sc_escaped) begin
          sc_escaped = 1'b0;
        end else if (b == CH_ESCAPE) begin
          sc_escaped = 1'b1;
        end else if (b == CH_QUOTE) begin
          push_pair(VK_STRING, sc_pos - sc_val_off);
          sc_phase = PH_BETWEEN;
        end
      end
      PH_LITERAL: begin
        word = lit_words[sc_lit_sel];
        if (sc_lit_prog < word.len() && b == word[sc_lit_prog]) begin
          sc_lit_prog++;
          if (sc_lit_prog >= word.len()) begin
            push_pair(value_kind_t'({1'b0, sc_lit_sel} + 3'd1), '0);
            sc_phase = PH_BETWEEN;
          end
        end else begin
          end_number(b);
        end
      end
      PH_NUMBER: end_number(b);
      default: ;
    endcase

    if (eom) begin
      end_pos = sc_pos + 1'b1;
      bad     = 1'b0;
      case (sc_phase)
        PH_AFTER_COLON: begin
          sc_val_off = end_pos;
          push_pair(VK_NUMBER, '0);
        end
        PH_STRING:             push_pair(VK_STRING, end_pos - sc_val_off);
        PH_LITERAL, PH_NUMBER: push_pair(VK_NUMBER, end_pos - sc_val_off);
        PH_BETWEEN, PH_CLOSED: ;
        default:               bad = 1'b1;
      endcase
      fin             = '0;
      fin.result_kind = bad ? RK_ERROR : RK_DONE;
      fin.pair_count  = bad ? '0 : sc_kept[CNT_W-1:0];
      fin.last_result = 1'b1;
      byte_results.push_back(fin);
      reset_scan();
    end else begin
      if (byte_results.size() > 0) byte_results[byte_results.size()-1].last_result = 1'b1;
      sc_pos = sc_pos + 1'b1;
    end
    foreach (byte_results[i]) scan_results_due.push_back(byte_results[i]);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // ---- message building ----
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_QUOTE || b == CH_ESCAPE) b = "z";
    return b;
  endfunction

  function automatic logic [7:0] number_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return num_chars[$urandom_range(0, num_chars.len()-1)];
    b = 8'($urandom_range(0, 255));
    if (b == CH_COMMA || b == CH_SPACE || b == CH_CLOSE) b = "7";
    return b;
  endfunction

  function automatic void commit_message();
    foreach (msg[i]) words_to_send.push_back('{msg[i], i == msg.size() - 1});
    msg = {};
  endfunction

  function automatic void send_text(input string s);
    msg = {};
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    commit_message();
  endfunction

  function automatic void build_object();
    int         pairs;
    int         cut;
    string      word;
    logic [7:0] b;
    msg = {};
    msg.push_back(CH_OPEN);
    pairs = $urandom_range(0, 5);
    for (int i = 0; i < pairs; i++) begin
      if (i > 0) msg.push_back(CH_COMMA);
      repeat ($urandom_range(0, 2)) msg.push_back(gap_chars[$urandom_range(0, 3)]);
      msg.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE) b = "_";
        msg.push_back(b);
      end
      msg.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 1)) msg.push_back(CH_SPACE);
      msg.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) msg.push_back(CH_SPACE);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          msg.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
              msg.push_back(CH_ESCAPE);
              msg.push_back(8'($urandom_range(0, 255)));
            end else begin
              msg.push_back(plain_byte());
            end
          end
          msg.push_back(CH_QUOTE);
        end
        3, 4, 5: begin
          word = lit_words[$urandom_range(0, 2)];
          for (int k = 0; k < word.len(); k++) msg.push_back(word[k]);
          if ($urandom_range(0, 9) == 0) msg.push_back("x");
        end
        6: begin
          word = lit_words[$urandom_range(0, 2)];
          cut  = $urandom_range(1, word.len() - 1);
          for (int k = 0; k < cut; k++) msg.push_back(word[k]);
          msg.push_back(number_byte());
        end
        7, 8: repeat ($urandom_range(1, 5)) msg.push_back(number_byte());
        default: ;
      endcase
    end
    if ($urandom_range(0, 6) != 0) begin
      msg.push_back(CH_CLOSE);
      repeat ($urandom_range(0, 2)) msg.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void mangle_message();
    int idx;
    idx = $urandom_range(0, msg.size() - 1);
    case ($urandom_range(0, 9))
      0: msg = msg[0:idx];
      1: msg[idx] = 8'($urandom_range(0, 255));
      2: msg.insert(idx, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endfunction

  function automatic void build_many_pairs();
    msg = {};
    msg.push_back(CH_OPEN);
    for (int i = 0; i < 40; i++) begin
      msg.push_back(CH_QUOTE);
      msg.push_back(8'(8'h61 + (i % 26)));
      msg.push_back(CH_QUOTE);
      msg.push_back(CH_COLON);
      msg.push_back(8'(8'h30 + (i % 10)));
      msg.push_back(CH_COMMA);
    end
    msg.push_back(CH_CLOSE);
  endfunction

  // ---- sender ----
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (push && !full) void'(words_to_send.pop_front());
      if (push && full) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push     <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        push           <= 1'b1;
        data_byte      <= words_to_send[0].data;
        end_of_message <= words_to_send[0].eom;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---- receiver ----
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit rx_want;

  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (!hold_done && bytes_in >= 200) begin
        hold_done <= 1'b1;
        hold_left <= 300;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(10, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       rx_want = 1'b1;
        1:       rx_want = 1'($urandom_range(0, 1));
        default: rx_want = ($urandom_range(0, 7) == 0);
      endcase
      pop <= rx_want && hold_left == 0 && !(!hold_done && bytes_in >= 200);
    end
  end

  // ---- monitor ----
  result_t due;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        scan_byte(data_byte, end_of_message);
        bytes_in <= bytes_in + 1;
      end
      if (pop && !empty) begin
        if (scan_results_due.size() == 0) begin
          $error("result word with no expectation waiting: kind %0d", result_kind);
          error_count++;
        end else begin
          due = scan_results_due.pop_front();
          check_field("result_kind",  32'(due.result_kind),  32'(result_kind));
          check_field("key_offset",   32'(due.key_offset),   32'(key_offset));
          check_field("key_length",   32'(due.key_length),   32'(key_length));
          check_field("value_offset", 32'(due.value_offset), 32'(value_offset));
          check_field("value_length", 32'(due.value_length), 32'(value_length));
          check_field("value_kind",   32'(due.value_kind),   32'(value_kind));
          check_field("pair_index",   32'(due.pair_index),   32'(pair_index));
          check_field("pair_count",   32'(due.pair_count),   32'(pair_count));
          check_field("last_result",  32'(due.last_result),  32'(last_result));
        end
      end
    end
  end

  // ---- watchdog ----
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- stimulus and end of run ----
  initial begin
    int n_rand;
    int iter;
    reset_scan();

    msg = {8'h00};
    commit_message();
    send_text("{a");
    send_text("{\"k");
    send_text("{\"\"x");
    send_text("{\"\":tr,\"\": \"\\");
    send_text("{\"\":null}");
    words_to_send[words_to_send.size()-1].eom = 1'b0;
    msg = {8'hFF};
    commit_message();
    send_text("{\"\":");

    n_rand = 0;
    iter   = 0;
    while (n_rand < 1200) begin
      if (iter == 15) begin
        build_many_pairs();
      end else if ($urandom_range(0, 19) == 0) begin
        msg = {};
        repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_object();
        if ($urandom_range(0, 4) == 0) mangle_message();
      end
      n_rand += msg.size();
      commit_message();
      iter++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (words_to_send.size() != 0 || push || scan_results_due.size() != 0);
    repeat (8) @(negedge clk);

    if (!empty) begin
      $error("result word left over with no expectation: kind %0d", result_kind);
      error_count++;
    end

    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
